>>> hdl/lbo_pkg.sv
// shared types, class codes and pair rule function for the line break opportunity core
package lbo_pkg;

    localparam int unsigned ClassWidth = 6;
    localparam int unsigned KindWidth  = 2;

    localparam logic [ClassWidth-1:0] LB_XX   = 6'd0;
    localparam logic [ClassWidth-1:0] LB_AL   = 6'd3;
    localparam logic [ClassWidth-1:0] LB_BA   = 6'd7;
    localparam logic [ClassWidth-1:0] LB_BB   = 6'd8;
    localparam logic [ClassWidth-1:0] LB_BK   = 6'd9;
    localparam logic [ClassWidth-1:0] LB_CB   = 6'd10;
    localparam logic [ClassWidth-1:0] LB_CL   = 6'd12;
    localparam logic [ClassWidth-1:0] LB_CP   = 6'd14;
    localparam logic [ClassWidth-1:0] LB_CR   = 6'd15;
    localparam logic [ClassWidth-1:0] LB_EB   = 6'd16;
    localparam logic [ClassWidth-1:0] LB_EM   = 6'd17;
    localparam logic [ClassWidth-1:0] LB_EX   = 6'd18;
    localparam logic [ClassWidth-1:0] LB_GL   = 6'd19;
    localparam logic [ClassWidth-1:0] LB_HH   = 6'd22;
    localparam logic [ClassWidth-1:0] LB_HL   = 6'd23;
    localparam logic [ClassWidth-1:0] LB_HY   = 6'd24;
    localparam logic [ClassWidth-1:0] LB_ID   = 6'd25;
    localparam logic [ClassWidth-1:0] LB_IN   = 6'd26;
    localparam logic [ClassWidth-1:0] LB_IS   = 6'd27;
    localparam logic [ClassWidth-1:0] LB_LF   = 6'd31;
    localparam logic [ClassWidth-1:0] LB_NL   = 6'd32;
    localparam logic [ClassWidth-1:0] LB_NS   = 6'd33;
    localparam logic [ClassWidth-1:0] LB_NU   = 6'd34;
    localparam logic [ClassWidth-1:0] LB_PO   = 6'd36;
    localparam logic [ClassWidth-1:0] LB_PR   = 6'd37;
    localparam logic [ClassWidth-1:0] LB_RI   = 6'd39;
    localparam logic [ClassWidth-1:0] LB_SP   = 6'd41;
    localparam logic [ClassWidth-1:0] LB_SY   = 6'd42;
    localparam logic [ClassWidth-1:0] LB_WJ   = 6'd45;
    localparam logic [ClassWidth-1:0] LB_ZW   = 6'd46;
    localparam logic [ClassWidth-1:0] LB_ZWJ  = 6'd47;
    localparam logic [ClassWidth-1:0] LB_LAST = 6'd47;

    localparam logic [KindWidth-1:0] KIND_NONE      = 2'd0;
    localparam logic [KindWidth-1:0] KIND_ALLOWED   = 2'd1;
    localparam logic [KindWidth-1:0] KIND_MANDATORY = 2'd2;

    typedef struct packed {
        logic [ClassWidth-1:0] prior_class;
        logic                  started;
        logic                  ri_parity;
    } lbo_state_t;

    typedef struct packed {
        logic                 valid;
        logic [KindWidth-1:0] kind;
    } lbo_result_t;

    function automatic logic is_letter(input logic [ClassWidth-1:0] c);
        return (c == LB_AL) || (c == LB_HL);
    endfunction

    function automatic logic is_ideo(input logic [ClassWidth-1:0] c);
        return (c == LB_ID) || (c == LB_EB) || (c == LB_EM);
    endfunction

    // break kind between previous class a and current class b, rule order matters
    function automatic logic [KindWidth-1:0] pair_rule(
        input logic [ClassWidth-1:0] a,
        input logic [ClassWidth-1:0] b
    );
        logic [KindWidth-1:0] k;
        priority if (a == LB_BK)                                   k = KIND_MANDATORY;
        else if (a == LB_CR && b == LB_LF)                         k = KIND_NONE;
        else if (a == LB_CR || a == LB_LF || a == LB_NL)           k = KIND_MANDATORY;
        else if (b == LB_BK || b == LB_CR || b == LB_LF || b == LB_NL)
                                                                   k = KIND_NONE;
        else if (b == LB_SP || b == LB_ZW)                         k = KIND_NONE;
        else if (a == LB_ZWJ)                                      k = KIND_NONE;
        else if (a == LB_WJ || b == LB_WJ)                         k = KIND_NONE;
        else if (a == LB_GL)                                       k = KIND_NONE;
        else if (b == LB_GL && a != LB_SP && a != LB_BA && a != LB_HY && a != LB_HH)
                                                                   k = KIND_NONE;
        else if (b == LB_CL || b == LB_CP || b == LB_EX || b == LB_SY)
                                                                   k = KIND_NONE;
        else if (b == LB_IS)                                       k = KIND_NONE;
        else if (a == LB_SP)                                       k = KIND_ALLOWED;
        else if (a == LB_CB || b == LB_CB)                         k = KIND_ALLOWED;
        else if (b == LB_BA || b == LB_HH || b == LB_HY || b == LB_NS)
                                                                   k = KIND_NONE;
        else if (a == LB_BB)                                       k = KIND_NONE;
        else if (a == LB_SY && b == LB_HL)                         k = KIND_NONE;
        else if (b == LB_IN)                                       k = KIND_NONE;
        else if (is_letter(a) && b == LB_NU)                       k = KIND_NONE;
        else if (a == LB_NU && is_letter(b))                       k = KIND_NONE;
        else if (a == LB_PR && is_ideo(b))                         k = KIND_NONE;
        else if (is_ideo(a) && b == LB_PO)                         k = KIND_NONE;
        else if (is_letter(a) && is_letter(b))                     k = KIND_NONE;
        else if (a == LB_IS && is_letter(b))                       k = KIND_NONE;
        else                                                       k = KIND_ALLOWED;
        return k;
    endfunction

endpackage

>>> hdl/line_break_opportunity_core.sv
// line break opportunity core: top level with state and result registers
// a result is registered on the input transfer that causes it and appears in the cycle after that transfer
// throughput: one input transfer per cycle while the result register is not stalled, set by the single decision step
// in_ready stays high while the result register is empty or being drained
// reset clears the state registers and the result valid flag at once
module line_break_opportunity_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lbo_pkg::ClassWidth-1:0]      lb_class,
    input  logic                                end_of_text,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lbo_pkg::KindWidth-1:0]       break_kind
);

    lbo_pkg::lbo_state_t               state_reg;
    lbo_pkg::lbo_state_t               state_next;
    lbo_pkg::lbo_result_t              result;
    logic                              out_valid_reg;
    logic [lbo_pkg::KindWidth-1:0]     break_kind_reg;
    logic                              in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    lbo_step u_step
    (
        .state       (state_reg),
        .lb_class    (lb_class),
        .end_of_text (end_of_text),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prior_class <= lbo_pkg::LB_XX;
            state_reg.started     <= 1'b0;
            state_reg.ri_parity   <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_fire && result.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && result.valid)
        begin
            break_kind_reg <= result.kind;
        end
    end

    assign out_valid  = out_valid_reg;
    assign break_kind = break_kind_reg;

endmodule

>>> hdl/lbo_step.sv
// combinational step: break decision and next state for one input transfer
module lbo_step
(
    input  lbo_pkg::lbo_state_t                 state,
    input  logic [lbo_pkg::ClassWidth-1:0]      lb_class,
    input  logic                                end_of_text,
    output lbo_pkg::lbo_state_t                 state_next,
    output lbo_pkg::lbo_result_t                result
);

    logic [lbo_pkg::ClassWidth-1:0] cls;

    assign cls = (lb_class > lbo_pkg::LB_LAST) ? lbo_pkg::LB_XX : lb_class;

    always_comb
    begin
        state_next   = state;
        result.valid = 1'b0;
        result.kind  = lbo_pkg::KIND_NONE;
        priority if (end_of_text)
        begin
            state_next.prior_class = lbo_pkg::LB_XX;
            state_next.started     = 1'b0;
            state_next.ri_parity   = 1'b0;
            result.valid           = state.started;
            result.kind            = lbo_pkg::KIND_MANDATORY;
        end
        else if (!state.started)
        begin
            state_next.prior_class = cls;
            state_next.started     = 1'b1;
            state_next.ri_parity   = 1'b0;
        end
        else if (state.prior_class == lbo_pkg::LB_RI && cls == lbo_pkg::LB_RI)
        begin
            // regional indicators pair up from the first of the run
            state_next.prior_class = cls;
            state_next.ri_parity   = ~state.ri_parity;
            result.valid           = 1'b1;
            result.kind            = state.ri_parity ? lbo_pkg::KIND_ALLOWED
                                                     : lbo_pkg::KIND_NONE;
        end
        else
        begin
            state_next.prior_class = cls;
            state_next.ri_parity   = 1'b0;
            result.valid           = 1'b1;
            result.kind            = lbo_pkg::pair_rule(state.prior_class, cls);
        end
    end

endmodule

>>> hdl/lbo_checker.sv
// port checker for the line break opportunity core, bound to the top level
module lbo_port_assertions
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                end_of_text,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [lbo_pkg::KindWidth-1:0]       break_kind
);

    // stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(break_kind))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> break_kind <= lbo_pkg::KIND_MANDATORY)
        else $error("undefined break kind");

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // end of text straight after end of text gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_text) ##1 (in_valid && in_ready && end_of_text)
        |=> !out_valid)
        else $error("result from end of text on empty text");

endmodule

bind line_break_opportunity_core lbo_port_assertions u_lbo_port_assertions (.*);

>>> dv/lbo_checker.sv
`timescale 1ns / 100ps
// checker for the line break opportunity core: predicts each break kind and compares transfers
module lbo_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [lbo_pkg::ClassWidth-1:0] lb_class,
    input  logic                           end_of_text,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [lbo_pkg::KindWidth-1:0]  break_kind,
    output int                             error_count,
    output int                             pending_breaks,
    output int                             breaks_checked
);

    logic [lbo_pkg::ClassWidth-1:0] last_class;
    logic                           text_open;
    logic                           ri_odd;
    logic [lbo_pkg::KindWidth-1:0]  expected_kinds[$];

    function automatic logic letter_class(input logic [lbo_pkg::ClassWidth-1:0] c);
        return (c == lbo_pkg::LB_AL) || (c == lbo_pkg::LB_HL);
    endfunction

    function automatic logic ideographic_class(input logic [lbo_pkg::ClassWidth-1:0] c);
        return (c == lbo_pkg::LB_ID) || (c == lbo_pkg::LB_EB) || (c == lbo_pkg::LB_EM);
    endfunction

    // break kind between class a and the following class b
    function automatic logic [lbo_pkg::KindWidth-1:0] break_between(
        input logic [lbo_pkg::ClassWidth-1:0] a,
        input logic [lbo_pkg::ClassWidth-1:0] b
    );
        if (a == lbo_pkg::LB_BK)
            return lbo_pkg::KIND_MANDATORY;
        if (a == lbo_pkg::LB_CR)
            return (b == lbo_pkg::LB_LF) ? lbo_pkg::KIND_NONE : lbo_pkg::KIND_MANDATORY;
        if (a == lbo_pkg::LB_LF || a == lbo_pkg::LB_NL)
            return lbo_pkg::KIND_MANDATORY;
        if (b == lbo_pkg::LB_BK || b == lbo_pkg::LB_CR || b == lbo_pkg::LB_LF
            || b == lbo_pkg::LB_NL || b == lbo_pkg::LB_SP || b == lbo_pkg::LB_ZW)
            return lbo_pkg::KIND_NONE;
        if (a == lbo_pkg::LB_ZWJ || a == lbo_pkg::LB_WJ || b == lbo_pkg::LB_WJ
            || a == lbo_pkg::LB_GL)
            return lbo_pkg::KIND_NONE;
        if (b == lbo_pkg::LB_GL && a != lbo_pkg::LB_SP && a != lbo_pkg::LB_BA
            && a != lbo_pkg::LB_HY && a != lbo_pkg::LB_HH)
            return lbo_pkg::KIND_NONE;
        if (b == lbo_pkg::LB_CL || b == lbo_pkg::LB_CP || b == lbo_pkg::LB_EX
            || b == lbo_pkg::LB_SY || b == lbo_pkg::LB_IS)
            return lbo_pkg::KIND_NONE;
        if (a == lbo_pkg::LB_SP || a == lbo_pkg::LB_CB || b == lbo_pkg::LB_CB)
            return lbo_pkg::KIND_ALLOWED;
        if (b == lbo_pkg::LB_BA || b == lbo_pkg::LB_HH || b == lbo_pkg::LB_HY
            || b == lbo_pkg::LB_NS || a == lbo_pkg::LB_BB)
            return lbo_pkg::KIND_NONE;
        if ((a == lbo_pkg::LB_SY && b == lbo_pkg::LB_HL) || b == lbo_pkg::LB_IN)
            return lbo_pkg::KIND_NONE;
        if ((letter_class(a) && b == lbo_pkg::LB_NU)
            || (a == lbo_pkg::LB_NU && letter_class(b)))
            return lbo_pkg::KIND_NONE;
        if ((a == lbo_pkg::LB_PR && ideographic_class(b))
            || (ideographic_class(a) && b == lbo_pkg::LB_PO))
            return lbo_pkg::KIND_NONE;
        if ((letter_class(a) || a == lbo_pkg::LB_IS) && letter_class(b))
            return lbo_pkg::KIND_NONE;
        return lbo_pkg::KIND_ALLOWED;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [lbo_pkg::ClassWidth-1:0] cls;
        logic [lbo_pkg::KindWidth-1:0]  kind;
        logic [lbo_pkg::KindWidth-1:0]  want;
        if (!rst_n)
        begin
            last_class = lbo_pkg::LB_XX;
            text_open = 1'b0;
            ri_odd = 1'b0;
            expected_kinds.delete();
            error_count = 0;
            breaks_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_kinds.size() == 0)
                begin
                    $display("%0t: break_kind expected none, actual %0d", $time, break_kind);
                    error_count++;
                end
                else
                begin
                    want = expected_kinds.pop_front();
                    breaks_checked++;
                    if (break_kind !== want)
                    begin
                        $display("%0t: break_kind expected %0d, actual %0d",
                                 $time, want, break_kind);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (end_of_text)
                begin
                    if (text_open)
                        expected_kinds.push_back(lbo_pkg::KIND_MANDATORY);
                    last_class = lbo_pkg::LB_XX;
                    text_open = 1'b0;
                    ri_odd = 1'b0;
                end
                else
                begin
                    cls = (lb_class > lbo_pkg::LB_LAST) ? lbo_pkg::LB_XX : lb_class;
                    if (!text_open)
                    begin
                        text_open = 1'b1;
                        ri_odd = 1'b0;
                    end
                    else
                    begin
                        // regional indicators pair up from the first of a run
                        if (last_class == lbo_pkg::LB_RI && cls == lbo_pkg::LB_RI)
                        begin
                            kind = ri_odd ? lbo_pkg::KIND_ALLOWED : lbo_pkg::KIND_NONE;
                            ri_odd = !ri_odd;
                        end
                        else
                        begin
                            kind = break_between(last_class, cls);
                            ri_odd = 1'b0;
                        end
                        expected_kinds.push_back(kind);
                    end
                    last_class = cls;
                end
            end
        end
        pending_breaks = expected_kinds.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// top of the line break opportunity core testbench: clock, reset, stimulus and verdict
module testbench;

    localparam int ItemTarget = 1150;
    localparam int MaxTextLen = 20;
    localparam logic [lbo_pkg::ClassWidth-1:0] ClassUnknownLow = 6'd48;
    localparam logic [lbo_pkg::ClassWidth-1:0] ClassUnknownTop = 6'd63;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [lbo_pkg::ClassWidth-1:0] lb_class;
    logic                           end_of_text;
    logic                           out_valid;
    logic                           out_ready;
    logic [lbo_pkg::KindWidth-1:0]  break_kind;

    int error_count;
    int pending_breaks;
    int breaks_checked;
    int send_idle_pct;
    int ready_idle_pct;
    int transfers_sent;
    int texts_sent;

    line_break_opportunity_core DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .lb_class    (lb_class),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .break_kind  (break_kind)
    );

    lbo_checker break_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .lb_class       (lb_class),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .break_kind     (break_kind),
        .error_count    (error_count),
        .pending_breaks (pending_breaks),
        .breaks_checked (breaks_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("line_break_opportunity_core verification failed");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= ready_idle_pct);
        end
    end

    function automatic logic [lbo_pkg::ClassWidth-1:0] random_class(
        input logic [lbo_pkg::ClassWidth-1:0] lo,
        input logic [lbo_pkg::ClassWidth-1:0] hi
    );
        int unsigned r;
        r = $urandom_range(int'(hi), int'(lo));
        return r[lbo_pkg::ClassWidth-1:0];
    endfunction

    function automatic logic [lbo_pkg::ClassWidth-1:0] rule_class();
        unique case ($urandom_range(30))
            0: return lbo_pkg::LB_BK;   1: return lbo_pkg::LB_CR;   2: return lbo_pkg::LB_LF;
            3: return lbo_pkg::LB_NL;   4: return lbo_pkg::LB_SP;   5: return lbo_pkg::LB_ZW;
            6: return lbo_pkg::LB_ZWJ;  7: return lbo_pkg::LB_WJ;   8: return lbo_pkg::LB_GL;
            9: return lbo_pkg::LB_BA;   10: return lbo_pkg::LB_HY;  11: return lbo_pkg::LB_HH;
            12: return lbo_pkg::LB_CL;  13: return lbo_pkg::LB_CP;  14: return lbo_pkg::LB_EX;
            15: return lbo_pkg::LB_SY;  16: return lbo_pkg::LB_IS;  17: return lbo_pkg::LB_CB;
            18: return lbo_pkg::LB_NS;  19: return lbo_pkg::LB_BB;  20: return lbo_pkg::LB_HL;
            21: return lbo_pkg::LB_IN;  22: return lbo_pkg::LB_AL;  23: return lbo_pkg::LB_NU;
            24: return lbo_pkg::LB_PR;  25: return lbo_pkg::LB_ID;  26: return lbo_pkg::LB_EB;
            27: return lbo_pkg::LB_EM;  28: return lbo_pkg::LB_PO;  29: return lbo_pkg::LB_RI;
            default: return lbo_pkg::LB_XX;
        endcase
    endfunction

    // one input transfer; idle cycles drop valid and scramble the class
    task automatic send_code(input logic [lbo_pkg::ClassWidth-1:0] cls, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            lb_class <= random_class('0, '1);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        lb_class <= cls;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        transfers_sent++;
    endtask

    task automatic send_text();
        int len;
        int pick;
        logic [lbo_pkg::ClassWidth-1:0] cls;
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, MaxTextLen);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                cls = rule_class();
            else if (pick < 65)
                cls = lbo_pkg::LB_RI;
            else if (pick < 72)
                cls = random_class(ClassUnknownLow, ClassUnknownTop);
            else
                cls = random_class('0, '1);
            send_code(cls, 1'b0);
        end
        // some texts run on into the next without an end marker
        if ($urandom_range(9) != 0)
            send_code(random_class('0, '1), 1'b1);
        texts_sent++;
    endtask

    task automatic drain_breaks();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_breaks != 0)
            @(negedge clk);
    endtask

    initial
    begin
        in_valid = 1'b0;
        lb_class = '0;
        end_of_text = 1'b0;
        rst_n = 1'b0;
        send_idle_pct = 19;
        ready_idle_pct = 59;
        transfers_sent = 0;
        texts_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty text, unknown classes, line ends, regional indicator runs
        send_code(lbo_pkg::LB_XX, 1'b1);
        send_code(ClassUnknownTop, 1'b0);
        send_code(ClassUnknownLow, 1'b0);
        send_code(lbo_pkg::LB_CR, 1'b0);
        send_code(lbo_pkg::LB_LF, 1'b0);
        send_code(lbo_pkg::LB_BK, 1'b0);
        send_code(lbo_pkg::LB_RI, 1'b0);
        send_code(lbo_pkg::LB_RI, 1'b0);
        send_code(lbo_pkg::LB_RI, 1'b0);
        send_code(lbo_pkg::LB_RI, 1'b0);
        send_code(lbo_pkg::LB_SP, 1'b0);
        send_code(lbo_pkg::LB_RI, 1'b0);
        send_code(lbo_pkg::LB_RI, 1'b0);
        send_code(lbo_pkg::LB_ZWJ, 1'b0);
        send_code(lbo_pkg::LB_AL, 1'b0);
        send_code(lbo_pkg::LB_NU, 1'b0);
        send_code(lbo_pkg::LB_GL, 1'b0);
        send_code(lbo_pkg::LB_ZW, 1'b0);
        send_code(lbo_pkg::LB_CB, 1'b0);
        send_code(lbo_pkg::LB_ID, 1'b0);
        send_code(lbo_pkg::LB_PO, 1'b0);
        send_code(ClassUnknownTop, 1'b1);
        send_code(lbo_pkg::LB_XX, 1'b1);
        send_code(lbo_pkg::LB_LAST, 1'b0);
        send_code(lbo_pkg::LB_XX, 1'b1);
        texts_sent += 4;
        drain_breaks();

        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 19;
                    ready_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    ready_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    ready_idle_pct = 0;
                end
            endcase
            while (transfers_sent < 25 + ItemTarget * (phase + 1) / 3)
                send_text();
            drain_breaks();
        end

        repeat (4) @(negedge clk);
        $display("covered %0d input transfers in %0d texts, %0d break kinds checked",
                 transfers_sent, texts_sent, breaks_checked);
        if (error_count == 0)
            $display("line_break_opportunity_core verification clean");
        else
            $display("line_break_opportunity_core verification failed");
        $finish;
    end

endmodule
